// File: src/tt_pkg.sv
// Timer table package: shared codes, command word type and default sizes.
// Used by the front, the back, the top level and the checker of the timer table.
package tt_pkg;

    localparam int DEF_TIMER_SLOTS = 32;
    localparam int DEF_TIME_BITS   = 32;
    // most expired timers reported by one check
    localparam int LIST_MAX        = 32;
    localparam int LIST_AW         = 5;

    // input opcodes
    localparam logic [2:0] OP_SET_ONCE = 3'd0;
    localparam logic [2:0] OP_SET_PER  = 3'd1;
    localparam logic [2:0] OP_DELETE   = 3'd2;
    localparam logic [2:0] OP_CHECK    = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_SET     = 3'd0;
    localparam logic [2:0] KIND_DELETE  = 3'd1;
    localparam logic [2:0] KIND_EXPIRED = 3'd2;
    localparam logic [2:0] KIND_CHECK   = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [2:0]  op;
        logic        reject;
        logic [7:0]  handler;
        logic [31:0] user_word;
        logic [31:0] context_req;
        logic [5:0]  target_id;
    } cmd_t;

endpackage

// File: src/tt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/tt_front.sv
// Timer table front: accepts input words, classifies them, queues commands.
// Depends on tt_pkg.
module tt_front #(
    parameter int TW = tt_pkg::DEF_TIME_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [143:0]   s_tdata,
    input  logic [2:0]     s_tuser,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output tt_pkg::cmd_t   cmd,
    output logic [TW-1:0]  cmd_now,
    output logic [TW-1:0]  cmd_ivl,
    output logic [TW-1:0]  cmd_key
);

    tt_pkg::cmd_t  q_cmd [2];
    logic [TW-1:0] q_now [2];
    logic [TW-1:0] q_ivl [2];
    logic [TW-1:0] q_key [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;

    logic [TW-1:0] in_now;
    logic [TW-1:0] in_ivl;
    logic [TW:0]   sum;
    logic          known;
    logic          push;
    logic          pop;
    tt_pkg::cmd_t  in_cmd;

    // classify the incoming word
    always_comb
    begin
        in_now = TW'(s_tdata[31:0]);
        in_ivl = TW'(s_tdata[63:32]);
        sum    = {1'b0, in_now} + {1'b0, in_ivl};
        known  = s_tuser inside {tt_pkg::OP_SET_ONCE, tt_pkg::OP_SET_PER, tt_pkg::OP_DELETE,
                                 tt_pkg::OP_CHECK, tt_pkg::OP_CLEAR};
        in_cmd.op          = s_tuser;
        in_cmd.reject      = (s_tdata[71:64] == 8'd0) || sum[TW];
        in_cmd.handler     = s_tdata[71:64];
        in_cmd.user_word   = s_tdata[103:72];
        in_cmd.context_req = s_tdata[135:104];
        in_cmd.target_id   = s_tdata[141:136];
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready && known;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_cmd[rd_ptr_reg];
    assign cmd_now   = q_now[rd_ptr_reg];
    assign cmd_ivl   = q_ivl[rd_ptr_reg];
    assign cmd_key   = q_key[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd[wr_ptr_reg] <= in_cmd;
            q_now[wr_ptr_reg] <= in_now;
            q_ivl[wr_ptr_reg] <= in_ivl;
            q_key[wr_ptr_reg] <= sum[TW-1:0];
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: src/tt_back.sv
// Timer table back: executes commands against the slot stores, scans for
// expired timers and drives the result register. Depends on tt_pkg, tt_ram.
module tt_back #(
    parameter int N  = tt_pkg::DEF_TIMER_SLOTS,
    parameter int TW = tt_pkg::DEF_TIME_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tt_pkg::cmd_t  cmd,
    input  logic [TW-1:0] cmd_now,
    input  logic [TW-1:0] cmd_ivl,
    input  logic [TW-1:0] cmd_key,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [87:0]   m_tdata,
    output logic [2:0]    m_tuser,
    output logic          m_tlast
);

    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);
    localparam int KW = TW + 32;
    localparam int PW = TW + 72;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FREE, ST_DEL, ST_CLR, ST_SCAN, ST_PICK,
        ST_EM_RD, ST_EM_RD2, ST_EM_OUT, ST_DONE
    } state_t;

    state_t        state_reg;
    tt_pkg::cmd_t  cur_reg;
    logic [TW-1:0] now_reg;
    logic [TW-1:0] ivl_reg;
    logic [TW-1:0] key_reg;
    logic [N-1:0]  valid_reg;
    logic [N-1:0]  per_reg;
    logic [N-1:0]  rep_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] dec_reg;
    logic [31:0]   stamp_reg;
    logic [IW:0]   idx_reg;
    logic          cmp_vld_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          best_found_reg;
    logic [TW-1:0] best_exp_reg;
    logic [31:0]   best_stamp_reg;
    logic [IW-1:0] best_slot_reg;
    logic [5:0]    list_n_reg;
    logic [5:0]    k_reg;
    logic [IW-1:0] slot_reg;

    logic          tvalid_reg;
    logic [2:0]    kind_reg;
    logic          ok_reg;
    logic [5:0]    id_reg;
    logic [7:0]    hnd_reg;
    logic [31:0]   uw_reg;
    logic [31:0]   cx_reg;
    logic [5:0]    act_reg;
    logic          last_reg;

    // memory ports
    logic            key_we;
    logic [IW-1:0]   key_waddr;
    logic [KW-1:0]   key_wdata;
    logic [IW-1:0]   key_raddr;
    logic [KW-1:0]   key_rdata;
    logic            pay_we;
    logic [PW-1:0]   pay_wdata;
    logic [PW-1:0]   pay_rdata;
    logic            list_we;
    logic [IW-1:0]   list_wdata;
    logic [IW-1:0]   list_rdata;

    logic          out_free;
    logic          in_range;
    logic [IW-1:0] idx;
    logic [TW-1:0] rd_exp;
    logic [31:0]   rd_stamp;
    logic          better;
    logic [TW:0]   rearm_sum;
    logic [TW-1:0] rearm_exp;
    logic [7:0]    tid_m1;
    logic          del_ok;

    assign out_free  = !tvalid_reg || m_tready;
    assign in_range  = (idx_reg < (IW + 1)'(N));
    assign idx       = idx_reg[IW-1:0];
    assign rd_exp    = key_rdata[KW-1:32];
    assign rd_stamp  = key_rdata[31:0];
    assign cmd_ready = (state_reg == ST_IDLE);
    assign tid_m1    = 8'(cur_reg.target_id) - 8'd1;
    assign del_ok    = (cur_reg.target_id != 6'd0)
                    && (32'(cur_reg.target_id) <= 32'(N))
                    && valid_reg[tid_m1[IW-1:0]];

    // pick the earliest due candidate seen so far
    always_comb
    begin
        better = cmp_vld_reg && valid_reg[cmp_idx_reg] && !rep_reg[cmp_idx_reg]
              && (rd_exp <= now_reg)
              && (!best_found_reg || (rd_exp < best_exp_reg)
                  || ((rd_exp == best_exp_reg) && (rd_stamp < best_stamp_reg)));
        rearm_sum = {1'b0, rd_exp} + {1'b0, pay_rdata[PW-1:72]};
        rearm_exp = rearm_sum[TW] ? {TW{1'b1}} : rearm_sum[TW-1:0];
    end

    // steer memory ports
    always_comb
    begin
        key_we     = 1'b0;
        key_waddr  = idx;
        key_wdata  = {key_reg, stamp_reg};
        pay_we     = 1'b0;
        pay_wdata  = {ivl_reg, cur_reg.handler, cur_reg.user_word, cur_reg.context_req};
        list_we    = 1'b0;
        list_wdata = best_slot_reg;
        if (state_reg == ST_SCAN)
        begin
            key_raddr = idx;
        end
        else if (state_reg == ST_EM_RD2)
        begin
            key_raddr = list_rdata;
        end
        else
        begin
            key_raddr = slot_reg;
        end
        case (state_reg)
            ST_FREE:
            begin
                if (!cur_reg.reject && in_range && !valid_reg[idx] && out_free)
                begin
                    key_we = 1'b1;
                    pay_we = 1'b1;
                end
            end
            ST_PICK:
            begin
                list_we = best_found_reg && (list_n_reg < 6'(tt_pkg::LIST_MAX));
            end
            ST_EM_OUT:
            begin
                key_waddr = slot_reg;
                key_wdata = {rearm_exp, stamp_reg};
                key_we    = out_free && per_reg[slot_reg];
            end
            default:
            begin
                key_we = 1'b0;
            end
        endcase
    end

    tt_ram #(.WIDTH(KW), .DEPTH(N), .AW(IW)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    tt_ram #(.WIDTH(PW), .DEPTH(N), .AW(IW)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (idx),
        .wdata (pay_wdata),
        .raddr (key_raddr),
        .rdata (pay_rdata)
    );

    tt_ram #(.WIDTH(IW), .DEPTH(tt_pkg::LIST_MAX), .AW(tt_pkg::LIST_AW)) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_n_reg[tt_pkg::LIST_AW-1:0]),
        .wdata (list_wdata),
        .raddr (k_reg[tt_pkg::LIST_AW-1:0]),
        .rdata (list_rdata)
    );

    // periodic flags, written on every accepted set
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            per_reg[idx] <= (cur_reg.op == tt_pkg::OP_SET_PER);
        end
    end

    // command sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            rep_reg        <= '0;
            count_reg      <= '0;
            dec_reg        <= '0;
            stamp_reg      <= '0;
            idx_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            list_n_reg     <= '0;
            k_reg          <= '0;
            tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (tvalid_reg && m_tready)
            begin
                tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg        <= cmd;
                        now_reg        <= cmd_now;
                        ivl_reg        <= cmd_ivl;
                        key_reg        <= cmd_key;
                        idx_reg        <= '0;
                        rep_reg        <= '0;
                        dec_reg        <= '0;
                        list_n_reg     <= '0;
                        cmp_vld_reg    <= 1'b0;
                        best_found_reg <= 1'b0;
                        case (cmd.op)
                            tt_pkg::OP_SET_ONCE, tt_pkg::OP_SET_PER: state_reg <= ST_FREE;
                            tt_pkg::OP_DELETE:                       state_reg <= ST_DEL;
                            tt_pkg::OP_CHECK:                        state_reg <= ST_SCAN;
                            default:                                 state_reg <= ST_CLR;
                        endcase
                    end
                end
                // hunt for the lowest free slot
                ST_FREE:
                begin
                    if (!cur_reg.reject && in_range && valid_reg[idx])
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (out_free)
                    begin
                        tvalid_reg <= 1'b1;
                        kind_reg   <= tt_pkg::KIND_SET;
                        hnd_reg    <= '0;
                        uw_reg     <= '0;
                        cx_reg     <= '0;
                        last_reg   <= 1'b1;
                        if (cur_reg.reject || !in_range)
                        begin
                            ok_reg  <= 1'b0;
                            id_reg  <= '0;
                            act_reg <= 6'(count_reg);
                        end
                        else
                        begin
                            valid_reg[idx] <= 1'b1;
                            count_reg      <= count_reg + 1'b1;
                            stamp_reg      <= stamp_reg + 32'd1;
                            ok_reg         <= 1'b1;
                            id_reg         <= 6'(idx_reg + 1'b1);
                            act_reg        <= 6'(count_reg + 1'b1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DEL:
                begin
                    if (out_free)
                    begin
                        tvalid_reg <= 1'b1;
                        kind_reg   <= tt_pkg::KIND_DELETE;
                        ok_reg     <= del_ok;
                        id_reg     <= cur_reg.target_id;
                        hnd_reg    <= '0;
                        uw_reg     <= '0;
                        cx_reg     <= '0;
                        last_reg   <= 1'b1;
                        if (del_ok)
                        begin
                            valid_reg[tid_m1[IW-1:0]] <= 1'b0;
                            count_reg                 <= count_reg - 1'b1;
                            act_reg                   <= 6'(count_reg - 1'b1);
                        end
                        else
                        begin
                            act_reg <= 6'(count_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_CLR:
                begin
                    if (out_free)
                    begin
                        valid_reg  <= '0;
                        count_reg  <= '0;
                        stamp_reg  <= '0;
                        tvalid_reg <= 1'b1;
                        kind_reg   <= tt_pkg::KIND_CLEAR;
                        ok_reg     <= 1'b0;
                        id_reg     <= '0;
                        hnd_reg    <= '0;
                        uw_reg     <= '0;
                        cx_reg     <= '0;
                        act_reg    <= '0;
                        last_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                // read every slot once, keep the earliest unreported due one
                ST_SCAN:
                begin
                    cmp_vld_reg <= in_range;
                    cmp_idx_reg <= idx;
                    if (in_range)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (better)
                    begin
                        best_found_reg <= 1'b1;
                        best_exp_reg   <= rd_exp;
                        best_stamp_reg <= rd_stamp;
                        best_slot_reg  <= cmp_idx_reg;
                    end
                    if (!in_range && !cmp_vld_reg)
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                // append the winner to the report list or start reporting
                ST_PICK:
                begin
                    if (list_we)
                    begin
                        rep_reg[best_slot_reg] <= 1'b1;
                        if (!per_reg[best_slot_reg])
                        begin
                            dec_reg <= dec_reg + 1'b1;
                        end
                        list_n_reg     <= list_n_reg + 6'd1;
                        best_found_reg <= 1'b0;
                        idx_reg        <= '0;
                        state_reg      <= ST_SCAN;
                    end
                    else
                    begin
                        count_reg <= count_reg - dec_reg;
                        k_reg     <= '0;
                        state_reg <= (list_n_reg == 6'd0) ? ST_DONE : ST_EM_RD;
                    end
                end
                ST_EM_RD:
                begin
                    state_reg <= ST_EM_RD2;
                end
                ST_EM_RD2:
                begin
                    slot_reg  <= list_rdata;
                    state_reg <= ST_EM_OUT;
                end
                // report one timer, then re-arm or free it
                ST_EM_OUT:
                begin
                    if (out_free)
                    begin
                        tvalid_reg <= 1'b1;
                        kind_reg   <= tt_pkg::KIND_EXPIRED;
                        ok_reg     <= 1'b0;
                        id_reg     <= 6'(32'(slot_reg) + 32'd1);
                        hnd_reg    <= pay_rdata[71:64];
                        uw_reg     <= pay_rdata[63:32];
                        cx_reg     <= pay_rdata[31:0];
                        act_reg    <= 6'(count_reg);
                        last_reg   <= 1'b0;
                        if (per_reg[slot_reg])
                        begin
                            stamp_reg <= stamp_reg + 32'd1;
                        end
                        else
                        begin
                            valid_reg[slot_reg] <= 1'b0;
                        end
                        k_reg     <= k_reg + 6'd1;
                        state_reg <= (k_reg + 6'd1 == list_n_reg) ? ST_DONE : ST_EM_RD;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        tvalid_reg <= 1'b1;
                        kind_reg   <= tt_pkg::KIND_CHECK;
                        ok_reg     <= 1'b0;
                        id_reg     <= '0;
                        hnd_reg    <= '0;
                        uw_reg     <= '0;
                        cx_reg     <= '0;
                        act_reg    <= 6'(count_reg);
                        last_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'd0, act_reg, cx_reg, uw_reg, hnd_reg, id_reg, ok_reg};

endmodule

// File: src/one_shot_and_periodic_timer_table.sv
// Timer table top level: front classifier and queue, back executor.
// Depends on tt_pkg, tt_front, tt_back (and tt_ram below it).
//
// Usage: each input word carries an opcode in s_axis_tuser and the current
// time, interval, handler, user arguments and delete id in s_axis_tdata.
// A set answers with the lowest free slot plus one (0 if rejected), a delete
// answers whether its slot was live, a check reports each due timer in expiry
// then insertion order and closes with a done word, a clear empties the table.
// Opcodes 5 to 7 are taken and dropped. Every result word carries the live count
// after the item; tlast marks the final word of an item.
// Timing: a two-entry command queue sits between the front and the back.
// A set steps through the slots up to the lowest free one. A check scans all
// TIMER_SLOTS slots through the key memory once per reported timer and once
// more to close. Reset empties the table and the queue at once; no clearing
// pass is needed. A stalled receiver holds the result register and the back;
// the front keeps taking words until the queue is full.
module one_shot_and_periodic_timer_table #(
    parameter int TIMER_SLOTS = tt_pkg::DEF_TIMER_SLOTS,
    parameter int TIME_BITS   = tt_pkg::DEF_TIME_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now[31:0], interval[63:32], handler[71:64], user_word[103:72],
    // context_req[135:104], target_id[141:136], zero fill
    input  logic [143:0] s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ok[0], slot_id[6:1], handler_out[14:7], user_word_out[46:15],
    // context_out[78:47], active_count[84:79], zero fill
    output logic [87:0]  m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    logic                 cmd_valid;
    logic                 cmd_ready;
    tt_pkg::cmd_t         cmd;
    logic [TIME_BITS-1:0] cmd_now;
    logic [TIME_BITS-1:0] cmd_ivl;
    logic [TIME_BITS-1:0] cmd_key;

    tt_front #(.TW(TIME_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cmd_now   (cmd_now),
        .cmd_ivl   (cmd_ivl),
        .cmd_key   (cmd_key)
    );

    tt_back #(.N(TIMER_SLOTS), .TW(TIME_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cmd_now   (cmd_now),
        .cmd_ivl   (cmd_ivl),
        .cmd_key   (cmd_key),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser),
        .m_tlast   (m_axis_tlast)
    );

endmodule

// File: src/tt_checker.sv
// Port-level checks for the timer table, bound to the top level.
// Depends on tt_pkg.
module tt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // hold a stalled result word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result word changed");

    // expired reports never close an item
    a_exp_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == tt_pkg::KIND_EXPIRED) |-> !m_axis_tlast)
        else $error("expired report marked last");

    // every other kind closes its item
    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != tt_pkg::KIND_EXPIRED) |-> m_axis_tlast)
        else $error("answer word not marked last");

    // a clear leaves no live timer
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == tt_pkg::KIND_CLEAR) |-> (m_axis_tdata[84:79] == 6'd0))
        else $error("clear done with live timers");

    // a rejected set carries id zero
    a_reject_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == tt_pkg::KIND_SET) && !m_axis_tdata[0]
        |-> (m_axis_tdata[6:1] == 6'd0))
        else $error("rejected set with nonzero id");

endmodule

bind one_shot_and_periodic_timer_table tt_checker u_tt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
